>>> rtl/core/c2p_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2p_pkg
// Shared types and constants for the 2D Euler conservative to primitive unit.
// ---------------------------------------------------------------------------
package c2p_pkg;

    // fixed point format
    localparam int FRAC_BITS   = 16;
    localparam int WORD_BITS   = 32;
    localparam int RHO_BITS    = WORD_BITS - 1;
    localparam int Q_BITS      = WORD_BITS + FRAC_BITS;
    localparam int DIV_CELLS   = Q_BITS;
    localparam int GAMMA_BITS  = 18;
    localparam logic [GAMMA_BITS-1:0] GAMMA_RESET = GAMMA_BITS'(91750);
    localparam logic [GAMMA_BITS-1:0] ONE_FIX     = GAMMA_BITS'(1 << FRAC_BITS);

    // divider lanes sharing one divisor
    localparam int N_LANES = 3;
    localparam int LANE_X  = 0;
    localparam int LANE_Y  = 1;
    localparam int LANE_E  = 2;

    // input item
    typedef struct packed {
        logic [RHO_BITS-1:0]         density;
        logic signed [WORD_BITS-1:0] momentum_x;
        logic signed [WORD_BITS-1:0] momentum_y;
        logic signed [WORD_BITS-1:0] total_energy;
        logic                        last_element;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [RHO_BITS-1:0]         density_out;
        logic signed [WORD_BITS-1:0] velocity_x;
        logic signed [WORD_BITS-1:0] velocity_y;
        logic signed [WORD_BITS-1:0] pressure;
        logic                        range_error;
        logic                        last_out;
    } t_out_item;

    // one restoring divider lane: partial remainder and numerator/quotient shift word
    typedef struct packed {
        logic [RHO_BITS-1:0] rem;
        logic [Q_BITS-1:0]   numq;
    } t_div_lane;

    // side data riding along with the division
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_e;
        logic zero;
        logic last;
    } t_side;

    // everything one divider cell holds
    typedef struct packed {
        logic [RHO_BITS-1:0]          rho;
        t_div_lane [N_LANES-1:0]      lane;
        t_side                        side;
    } t_div_stage;

endpackage

>>> rtl/core/c2p_stream_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2p_stream_if
// Valid/ready channels carrying input and result items.
// ---------------------------------------------------------------------------
interface c2p_in_if;
    import c2p_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface c2p_out_if;
    import c2p_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/c2p_div_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2p_div_cell
// One restoring division step for three numerators over a shared divisor.
// ---------------------------------------------------------------------------
module c2p_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic                i_vld,
    input  c2p_pkg::t_div_stage i_stage,
    output logic                o_vld,
    output c2p_pkg::t_div_stage o_stage
);
    import c2p_pkg::*;

    logic       r_vld;
    t_div_stage r_stage;
    t_div_stage n_stage;

    // one quotient bit per lane
    always_comb begin
        logic [RHO_BITS:0] trial;
        n_stage = i_stage;
        for (int l = 0; l < N_LANES; l++) begin
            trial = {i_stage.lane[l].rem, i_stage.lane[l].numq[Q_BITS-1]};
            if (trial >= {1'b0, i_stage.rho}) begin
                n_stage.lane[l].rem  = RHO_BITS'(trial - {1'b0, i_stage.rho});
                n_stage.lane[l].numq = {i_stage.lane[l].numq[Q_BITS-2:0], 1'b1};
            end else begin
                n_stage.lane[l].rem  = trial[RHO_BITS-1:0];
                n_stage.lane[l].numq = {i_stage.lane[l].numq[Q_BITS-2:0], 1'b0};
            end
        end
    end

    // cell registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

>>> rtl/core/c2p_post.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// c2p_post
// Saturation, kinetic term and pressure product after the divider chain.
// ---------------------------------------------------------------------------
module c2p_post (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic                       i_vld,
    input  c2p_pkg::t_div_stage        i_stage,
    input  logic [c2p_pkg::GAMMA_BITS-1:0] i_gamma,
    output logic                       o_vld,
    output c2p_pkg::t_out_item         o_item
);
    import c2p_pkg::*;

    localparam int SAT_W  = 67;
    localparam int ES_W   = Q_BITS + 1;
    localparam int D_W    = Q_BITS + 2;
    localparam int HALF_W = D_W / 2;
    localparam int G_W    = RHO_BITS + GAMMA_BITS - FRAC_BITS;
    localparam int PP_W   = G_W + HALF_W;
    localparam int PROD_W = G_W + D_W;
    localparam int SQ_W   = 2 * WORD_BITS;
    localparam logic [SAT_W-1:0] MAX_POS  = SAT_W'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [SAT_W-1:0] MAX_NEG  = SAT_W'(64'd1 << (WORD_BITS - 1));

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [WORD_BITS-1:0] mag;
        logic                 err;
    } t_sat;

    typedef struct packed {
        logic [RHO_BITS-1:0]  rho;
        logic [WORD_BITS-1:0] u;
        logic [WORD_BITS-1:0] v;
        logic                 err;
        logic                 zero;
        logic                 last;
    } t_pass;

    function automatic t_sat sat_word(input logic neg, input logic [SAT_W-1:0] mag);
        t_sat s;
        s.err = 1'b0;
        if (!neg) begin
            if (mag > MAX_POS) begin
                s.word = MAX_POS[WORD_BITS-1:0];
                s.err  = 1'b1;
            end else begin
                s.word = mag[WORD_BITS-1:0];
            end
            s.mag = s.word;
        end else begin
            if (mag > MAX_NEG) begin
                s.mag = MAX_NEG[WORD_BITS-1:0];
                s.err = 1'b1;
            end else begin
                s.mag = mag[WORD_BITS-1:0];
            end
            s.word = WORD_BITS'(0) - s.mag;
        end
        return s;
    endfunction

    // stage 1: saturate velocities, sign energy quotient, rho*(gamma-1)
    logic                        r1_vld;
    t_pass                       r1_pass;
    logic [WORD_BITS-1:0]        r1_umag, r1_vmag;
    logic signed [ES_W-1:0]      r1_es;
    logic [RHO_BITS+GAMMA_BITS-1:0] r1_gfull;
    t_pass                       n1_pass;
    t_sat                        n1_u, n1_v;
    logic [GAMMA_BITS-1:0]       w_gm1mag;
    logic                        w_gneg;

    assign w_gneg   = i_gamma < ONE_FIX;
    assign w_gm1mag = w_gneg ? (ONE_FIX - i_gamma) : (i_gamma - ONE_FIX);

    always_comb begin
        n1_u = sat_word(i_stage.side.neg_x, SAT_W'(i_stage.lane[LANE_X].numq));
        n1_v = sat_word(i_stage.side.neg_y, SAT_W'(i_stage.lane[LANE_Y].numq));
        n1_pass.rho  = i_stage.rho;
        n1_pass.u    = n1_u.word;
        n1_pass.v    = n1_v.word;
        n1_pass.err  = n1_u.err | n1_v.err;
        n1_pass.zero = i_stage.side.zero;
        n1_pass.last = i_stage.side.last;
    end

    // stage 2: squares
    logic                 r2_vld;
    t_pass                r2_pass;
    logic [SQ_W-1:0]      r2_usq, r2_vsq;
    logic signed [ES_W-1:0] r2_es;
    logic [G_W-1:0]       r2_g;

    // stage 3: difference e - k
    logic                 r3_vld;
    t_pass                r3_pass;
    logic                 r3_dneg;
    logic [D_W-1:0]       r3_dmag;
    logic [G_W-1:0]       r3_g;
    logic [SQ_W:0]        w_ksum;
    logic signed [D_W-1:0] w_d;

    assign w_ksum = {1'b0, r2_usq} + {1'b0, r2_vsq};
    assign w_d    = D_W'(r2_es) - $signed({2'b00, w_ksum[SQ_W:FRAC_BITS+1]});

    // stage 4: split pressure product
    logic                 r4_vld;
    t_pass                r4_pass;
    logic                 r4_pneg;
    logic [PP_W-1:0]      r4_plo, r4_phi;

    // stage 5: recombine, saturate, result register
    logic                 r5_vld;
    t_out_item            r5_item;
    t_out_item            n5_item;
    logic [PROD_W-1:0]    w_prod;
    t_sat                 w_p;

    assign w_prod = PROD_W'(r4_plo) + {r4_phi, HALF_W'(0)};
    assign w_p    = sat_word(r4_pneg, w_prod[PROD_W-1:FRAC_BITS]);

    always_comb begin
        if (r4_pass.zero) begin
            n5_item.density_out = '0;
            n5_item.velocity_x  = '0;
            n5_item.velocity_y  = '0;
            n5_item.pressure    = '0;
            n5_item.range_error = 1'b1;
        end else begin
            n5_item.density_out = r4_pass.rho;
            n5_item.velocity_x  = r4_pass.u;
            n5_item.velocity_y  = r4_pass.v;
            n5_item.pressure    = w_p.word;
            n5_item.range_error = r4_pass.err | w_p.err;
        end
        n5_item.last_out = r4_pass.last;
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_adv) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_pass  <= n1_pass;
            r1_umag  <= n1_u.mag;
            r1_vmag  <= n1_v.mag;
            r1_es    <= i_stage.side.neg_e ? -$signed({1'b0, i_stage.lane[LANE_E].numq})
                                          :  $signed({1'b0, i_stage.lane[LANE_E].numq});
            r1_gfull <= i_stage.rho * w_gm1mag;

            r2_pass  <= r1_pass;
            r2_usq   <= r1_umag * r1_umag;
            r2_vsq   <= r1_vmag * r1_vmag;
            r2_es    <= r1_es;
            r2_g     <= r1_gfull[RHO_BITS+GAMMA_BITS-1:FRAC_BITS];

            r3_pass  <= r2_pass;
            r3_dneg  <= w_d[D_W-1];
            r3_dmag  <= w_d[D_W-1] ? D_W'(-w_d) : D_W'(w_d);
            r3_g     <= r2_g;

            r4_pass  <= r3_pass;
            r4_pneg  <= r3_dneg ^ w_gneg;
            r4_plo   <= r3_g * r3_dmag[HALF_W-1:0];
            r4_phi   <= r3_g * r3_dmag[D_W-1:HALF_W];

            r5_item  <= n5_item;
        end
    end

    assign o_vld  = r5_vld;
    assign o_item = r5_item;

endmodule

>>> rtl/core/conservative_to_primitive_2d_unit.sv
`timescale 1ns / 1ps
// Item path: 48 divider cells + 5 post stages between item acceptance and result valid.
// Throughput: one item per cycle unless stalled; the 48-cell restoring divider chain
// retires one quotient bit per cell for all three numerators, and the post stages are fully pipelined.
// A stalled result freezes the whole chain; input ready follows result ready or a free slot.
// Reset (synchronous, active low) clears all valid bits and sets gamma_ratio to 1.4.
// ---------------------------------------------------------------------------
// conservative_to_primitive_2d_unit
// Converts a cell's conserved 2D Euler state into density, velocity and pressure.
// ---------------------------------------------------------------------------
module conservative_to_primitive_2d_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [c2p_pkg::GAMMA_BITS-1:0] i_cfg_wr_data,
    c2p_in_if.sink                         i_in,
    c2p_out_if.source                      o_out
);
    import c2p_pkg::*;

    logic                  r_gamma;
    logic [GAMMA_BITS-1:0] r_gamma_ratio;
    logic                  w_adv;
    logic [DIV_CELLS:0]    w_vld;
    t_div_stage            w_stage [DIV_CELLS+1];
    t_div_stage            w_head;
    logic                  w_neg [N_LANES];
    logic [WORD_BITS-1:0]  w_raw [N_LANES];

    // gamma register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma_ratio <= GAMMA_RESET;
            r_gamma       <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_gamma_ratio <= i_cfg_wr_data;
            r_gamma       <= 1'b1;
        end
    end

    // global advance: the result slot is empty or being taken
    assign w_adv       = !o_out.valid || o_out.ready;
    assign i_in.ready  = w_adv;

    // split inputs into sign and magnitude, load the first cell
    assign w_raw[LANE_X] = i_in.data.momentum_x;
    assign w_raw[LANE_Y] = i_in.data.momentum_y;
    assign w_raw[LANE_E] = i_in.data.total_energy;

    always_comb begin
        logic [WORD_BITS-1:0] mag;
        w_head.rho = i_in.data.density;
        for (int l = 0; l < N_LANES; l++) begin
            w_neg[l] = w_raw[l][WORD_BITS-1];
            mag      = w_neg[l] ? (WORD_BITS'(0) - w_raw[l]) : w_raw[l];
            w_head.lane[l].rem  = '0;
            w_head.lane[l].numq = {mag, FRAC_BITS'(0)};
        end
        w_head.side.neg_x = w_neg[LANE_X];
        w_head.side.neg_y = w_neg[LANE_Y];
        w_head.side.neg_e = w_neg[LANE_E];
        w_head.side.zero  = (i_in.data.density == '0);
        w_head.side.last  = i_in.data.last_element;
    end

    assign w_vld[0]   = i_in.valid;
    assign w_stage[0] = w_head;

    // divider chain
    for (genvar c = 0; c < DIV_CELLS; c++) begin : g_cell
        c2p_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_vld[c]),
            .i_stage (w_stage[c]),
            .o_vld   (w_vld[c+1]),
            .o_stage (w_stage[c+1])
        );
    end

    // post processing and result register
    c2p_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_vld[DIV_CELLS]),
        .i_stage (w_stage[DIV_CELLS]),
        .i_gamma (r_gamma_ratio),
        .o_vld   (o_out.valid),
        .o_item  (o_out.data)
    );

    // a zero density result carries the error flag and cleared fields
    a_zero_rho : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.density_out == '0 |->
            o_out.data.range_error && o_out.data.velocity_x == '0 &&
            o_out.data.velocity_y == '0 && o_out.data.pressure == '0)
        else $error("zero density result not cleared");

    // nothing comes out right after reset
    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("result valid after reset");

    // the divider chain holds while the result is stalled
    a_chain_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_vld[DIV_CELLS:1]))
        else $error("divider chain moved during stall");

    // gamma keeps its value unless written
    a_gamma_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gamma && !$past(i_cfg_wr_en) |-> $stable(r_gamma_ratio))
        else $error("gamma changed without a write");

endmodule
